FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRIO_W = 8;
    localparam int TAG_W  = 16;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  tag;
    } t_req;

    typedef struct packed {
        logic              popped_valid;
        logic [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]  out_tag;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    typedef enum logic {
        CS_EMPTY,
        CS_HOLD
    } t_ctl_state;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

FILE: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: tracks the response register and issues the
// execute command to the datapath when a request is accepted.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_stall = 1'b0;
        o_rsp_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        unique case (r_state)
            CS_EMPTY: begin
                if (i_req_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = CS_HOLD;
                end
            end
            CS_HOLD: begin
                o_rsp_valid = 1'b1;
                // A new request may enter in the cycle the held response leaves.
                o_req_stall = i_rsp_stall;
                if (!i_rsp_stall) begin
                    o_cmd.exec = i_req_valid;
                    n_state    = i_req_valid ? CS_HOLD : CS_EMPTY;
                end
            end
            default: begin
                n_state = CS_EMPTY;
            end
        endcase
    end

    a_exec_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_rsp_valid)
        else $error("executed request did not produce a response");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> o_rsp_valid)
        else $error("request stalled with no response held");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |-> !o_cmd.exec)
        else $error("held response overwritten while stalled");

endmodule

FILE: rtl/spq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// Sorted register array with per-cell compare, occupancy count and the
// response register.
// ----------------------------------------------------------------------------
module spq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spq_pkg::t_dp_cmd i_cmd,
    input  spq_pkg::t_req    i_req,
    output spq_pkg::t_rsp    o_rsp
);
    import spq_pkg::*;

    logic [PRIO_W-1:0] r_prio [DEPTH];
    logic [TAG_W-1:0]  r_tag  [DEPTH];
    logic [PRIO_W-1:0] n_prio [DEPTH];
    logic [TAG_W-1:0]  n_tag  [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    logic [PRIO_W-1:0] up_prio [DEPTH];
    logic [TAG_W-1:0]  up_tag  [DEPTH];
    logic [PRIO_W-1:0] dn_prio [DEPTH];
    logic [TAG_W-1:0]  dn_tag  [DEPTH];
    logic [DEPTH-1:0]  le;
    logic [DEPTH-1:0]  le_prev;
    logic              full;
    logic              empty;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Cells holding an entry of equal or smaller priority keep it; since the
    // array is sorted these form a prefix, and the new entry goes right after.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = (CNT_W'(i) < r_count) && (r_prio[i] <= i_req.priority_req);
        end
        le_prev[0] = 1'b1;
        up_prio[0] = i_req.priority_req;
        up_tag[0]  = i_req.tag;
        for (int i = 1; i < DEPTH; i++) begin
            le_prev[i] = le[i-1];
            up_prio[i] = r_prio[i-1];
            up_tag[i]  = r_tag[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            dn_prio[i] = r_prio[i+1];
            dn_tag[i]  = r_tag[i+1];
        end
        dn_prio[DEPTH-1] = r_prio[DEPTH-1];
        dn_tag[DEPTH-1]  = r_tag[DEPTH-1];
    end

    always_comb begin
        n_prio  = r_prio;
        n_tag   = r_tag;
        n_count = r_count;
        n_rsp   = '0;
        n_rsp.status = STAT_OK;
        case (i_req.mode)
            MODE_ENQ: begin
                if (full) begin
                    n_rsp.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!le[i]) begin
                            if (le_prev[i]) begin
                                n_prio[i] = i_req.priority_req;
                                n_tag[i]  = i_req.tag;
                            end else begin
                                n_prio[i] = up_prio[i];
                                n_tag[i]  = up_tag[i];
                            end
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_DEQ: begin
                if (empty) begin
                    n_rsp.status = STAT_EMPTY;
                end else begin
                    n_rsp.popped_valid = 1'b1;
                    n_rsp.out_priority = r_prio[0];
                    n_rsp.out_tag      = r_tag[0];
                    n_prio  = dn_prio;
                    n_tag   = dn_tag;
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_FLUSH: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_rsp.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_prio <= n_prio;
            r_tag  <= n_tag;
            r_rsp  <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy exceeds queue depth");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_req.mode == MODE_DEQ && !empty)
            |=> (r_count == $past(r_count) - CNT_W'(1)) && r_rsp.popped_valid)
        else $error("dequeue did not remove exactly one entry");

endmodule

FILE: rtl/stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded min-first priority queue with stable ordering among equal values.
// ----------------------------------------------------------------------------
// Latency: the response is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken without stall;
// every cell of the sorted register array compares and shifts in that cycle.
// Reset clears the occupancy count and the response valid; entry contents
// are left as they are and are never read before being written.
module stable_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  spq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output spq_pkg::t_rsp o_rsp
);
    import spq_pkg::*;

    t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (w_cmd)
    );

    spq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
